// ===== rtl/mis_pkg.sv =====
// ----------------------------------------------------------------------------
// mis_pkg
// Types and constants shared by the mask IoU shape similarity block.
// ----------------------------------------------------------------------------
package mis_pkg;

   localparam int LANES      = 8;
   localparam int MASK_W     = 8;
   localparam int MAX_PIXELS = 1048576;
   localparam int CNT_W      = 21;
   localparam int POP_W      = $clog2(LANES + 1);
   localparam int NORM_W     = 16;
   localparam int PROD_W     = 2 * NORM_W;
   localparam int DOT_W      = 36;
   localparam int NUM_W      = 8;
   localparam int THR_W      = 15;
   localparam int RATIO_W    = CNT_W + NUM_W;

   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int ADDR_W     = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [1:0] REG_RATIO_NUM = 2'd0;
   localparam logic [1:0] REG_RATIO_DEN = 2'd1;
   localparam logic [1:0] REG_AGREE_MIN = 2'd2;

   localparam logic [NUM_W-1:0] RATIO_NUM_RESET = 8'd1;
   localparam logic [NUM_W-1:0] RATIO_DEN_RESET = 8'd5;
   localparam logic [THR_W-1:0] AGREE_MIN_RESET = 15'd15565;

   typedef struct packed {
      logic [NUM_W-1:0] ratio_num;
      logic [NUM_W-1:0] ratio_den;
      logic [THR_W-1:0] agree_min;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              self_cyl;
      logic              other_cyl;
      logic [CNT_W-1:0]  inter;
      logic [CNT_W-1:0]  uni;
   } judge_req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
   } normal_type;

endpackage

// ===== rtl/mask_iou_shape_similarity.sv =====
// ----------------------------------------------------------------------------
// mask_iou_shape_similarity
// Counts union and intersection pixels of two masks, eight lanes a beat,
// and judges on the last beat whether the two shapes match.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while req_tready (judge first stage free) is high,
//   set by the eight pixel lanes and the saturating accumulate of the totals.
// Result path: after the edge that transfers the last beat, the verdict passes the
//   product, sum and decision register stages of the judge.
// Reset: synchronous; clears totals, pipeline valids and loads the
//   register defaults (num 1, den 5, threshold 15565).
module mask_iou_shape_similarity
   import mis_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: mask_self_bits[7:0], mask_other_bits[15:8], normal_self_x[31:16],
   //   normal_self_y[47:32], normal_self_z[63:48], normal_other_x[79:64],
   //   normal_other_y[95:80], normal_other_z[111:96]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tlast,
   // req_tuser: self_is_cylinder[0], other_is_cylinder[1]
   input  logic [REQ_USER_W-1:0]  req_tuser,
   // rsp_tdata: similar[0], intersection_count[21:1], union_count[42:22], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [NUM_W-1:0] ratio_num_ff, ratio_num_in;
   logic [NUM_W-1:0] ratio_den_ff, ratio_den_in;
   logic [THR_W-1:0] agree_min_ff, agree_min_in;
   logic             csr_write;
   logic [1:0]       csr_index;

   logic [MASK_W-1:0] mask_self, mask_other;
   logic [LANES-1:0]  union_bits, inter_bits;
   logic              beat_take;
   logic [CNT_W-1:0]  union_next, inter_next;
   cfg_type           cfg;
   judge_req_type     jreq;
   normal_type        n_self, n_other;
   logic              judge_free;
   logic              out_similar;
   logic [CNT_W-1:0]  out_inter, out_union;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      ratio_num_in = ratio_num_ff;
      ratio_den_in = ratio_den_ff;
      agree_min_in = agree_min_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_RATIO_NUM: ratio_num_in = csr_pwdata[NUM_W-1:0];
            REG_RATIO_DEN: ratio_den_in = csr_pwdata[NUM_W-1:0];
            REG_AGREE_MIN: agree_min_in = csr_pwdata[THR_W-1:0];
            default:       ratio_num_in = ratio_num_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_RATIO_NUM: csr_prdata = CSR_DATA_W'(ratio_num_ff);
         REG_RATIO_DEN: csr_prdata = CSR_DATA_W'(ratio_den_ff);
         REG_AGREE_MIN: csr_prdata = CSR_DATA_W'(agree_min_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_num_ff <= RATIO_NUM_RESET;
         ratio_den_ff <= RATIO_DEN_RESET;
         agree_min_ff <= AGREE_MIN_RESET;
      end else begin
         ratio_num_ff <= ratio_num_in;
         ratio_den_ff <= ratio_den_in;
         agree_min_ff <= agree_min_in;
      end
   end

   assign cfg.ratio_num = ratio_num_ff;
   assign cfg.ratio_den = ratio_den_ff;
   assign cfg.agree_min = agree_min_ff;

   // pixel lanes
   assign mask_self  = req_tdata[7:0];
   assign mask_other = req_tdata[15:8];

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      mis_lane u_lane (
         .self_bit  (mask_self[g]),
         .other_bit (mask_other[g]),
         .union_bit (union_bits[g]),
         .inter_bit (inter_bits[g])
      );
   end

   assign req_tready = judge_free;
   assign beat_take  = req_tvalid && req_tready;

   mis_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .union_bits (union_bits),
      .inter_bits (inter_bits),
      .beat_take  (beat_take),
      .beat_last  (req_tlast),
      .union_next (union_next),
      .inter_next (inter_next)
   );

   assign jreq.valid     = beat_take && req_tlast;
   assign jreq.self_cyl  = req_tuser[0];
   assign jreq.other_cyl = req_tuser[1];
   assign jreq.inter     = inter_next;
   assign jreq.uni       = union_next;

   assign n_self.x  = req_tdata[31:16];
   assign n_self.y  = req_tdata[47:32];
   assign n_self.z  = req_tdata[63:48];
   assign n_other.x = req_tdata[79:64];
   assign n_other.y = req_tdata[95:80];
   assign n_other.z = req_tdata[111:96];

   mis_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (jreq),
      .n_self      (n_self),
      .n_other     (n_other),
      .req_free    (judge_free),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_similar (out_similar),
      .out_inter   (out_inter),
      .out_union   (out_union)
   );

   assign rsp_tdata = {5'd0, out_union, out_inter, out_similar};

endmodule

// ===== rtl/mis_lane.sv =====
// ----------------------------------------------------------------------------
// mis_lane
// One pixel lane: union and intersection flags of a pixel pair.
// ----------------------------------------------------------------------------
module mis_lane
   import mis_pkg::*;
(
   input  logic self_bit,
   input  logic other_bit,
   output logic union_bit,
   output logic inter_bit
);

   assign union_bit = self_bit | other_bit;
   assign inter_bit = self_bit & other_bit;

endmodule

// ===== rtl/mis_merge.sv =====
// ----------------------------------------------------------------------------
// mis_merge
// Merges the lane flags into pixel counts and keeps the saturating totals.
// ----------------------------------------------------------------------------
module mis_merge
   import mis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LANES-1:0]  union_bits,
   input  logic [LANES-1:0]  inter_bits,
   input  logic              beat_take,
   input  logic              beat_last,
   output logic [CNT_W-1:0]  union_next,
   output logic [CNT_W-1:0]  inter_next
);

   logic [CNT_W-1:0] union_ff, union_in;
   logic [CNT_W-1:0] inter_ff, inter_in;
   logic [POP_W-1:0] union_pop, inter_pop;
   logic [CNT_W:0]   union_sum, inter_sum;

   always_comb begin
      union_pop = '0;
      inter_pop = '0;
      for (int k = 0; k < LANES; k++) begin
         union_pop = union_pop + POP_W'(union_bits[k]);
         inter_pop = inter_pop + POP_W'(inter_bits[k]);
      end
   end

   always_comb begin
      union_sum = {1'b0, union_ff} + (CNT_W + 1)'(union_pop);
      inter_sum = {1'b0, inter_ff} + (CNT_W + 1)'(inter_pop);
      union_next = (union_sum > (CNT_W + 1)'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                          : union_sum[CNT_W-1:0];
      inter_next = (inter_sum > (CNT_W + 1)'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                          : inter_sum[CNT_W-1:0];
   end

   // totals restart after the closing beat of a pair
   always_comb begin
      union_in = union_ff;
      inter_in = inter_ff;
      if (beat_take) begin
         union_in = beat_last ? '0 : union_next;
         inter_in = beat_last ? '0 : inter_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         union_ff <= '0;
         inter_ff <= '0;
      end else begin
         union_ff <= union_in;
         inter_ff <= inter_in;
      end
   end

endmodule

// ===== rtl/mis_judge.sv =====
// ----------------------------------------------------------------------------
// mis_judge
// Three-stage decision pipeline: normal products, dot sum and ratio
// products, then the overlap and normal tests into the output register.
// ----------------------------------------------------------------------------
module mis_judge
   import mis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  judge_req_type     req,
   input  normal_type        n_self,
   input  normal_type        n_other,
   output logic              req_free,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_similar,
   output logic [CNT_W-1:0]  out_inter,
   output logic [CNT_W-1:0]  out_union
);

   // stage 1
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_scyl_ff, s1_ocyl_ff;
   logic [CNT_W-1:0]          s1_inter_ff, s1_union_ff;
   logic signed [PROD_W-1:0]  s1_px_ff, s1_py_ff, s1_pz_ff;
   // stage 2
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_scyl_ff, s2_ocyl_ff;
   logic [CNT_W-1:0]          s2_inter_ff, s2_union_ff;
   logic signed [DOT_W-1:0]   s2_dot_ff, s2_dot_in;
   logic [RATIO_W-1:0]        s2_iden_ff, s2_unum_ff;
   // output
   logic                      o_valid_ff, o_valid_in;
   logic                      o_sim_ff, o_sim_in;
   logic [CNT_W-1:0]          o_inter_ff, o_union_ff;

   logic o_free, s2_free, s1_free, s1_load, s2_load, o_load;
   logic signed [DOT_W-1:0] thr_ext, dot_abs;
   logic overlap_ok, plane_ok, cyl_ok;

   assign o_free  = !o_valid_ff || out_ready;
   assign s2_free = !s2_valid_ff || o_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s1_load = req.valid && s1_free;
   assign s2_load = s1_valid_ff && s2_free;
   assign o_load  = s2_valid_ff && o_free;

   assign req_free = s1_free;

   always_comb begin
      s1_valid_in = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      s2_valid_in = s2_load ? 1'b1 : (o_load ? 1'b0 : s2_valid_ff);
      o_valid_in  = o_load ? 1'b1 : ((o_valid_ff && out_ready) ? 1'b0 : o_valid_ff);
   end

   always_comb begin
      s2_dot_in = DOT_W'(s1_px_ff) + DOT_W'(s1_py_ff) + DOT_W'(s1_pz_ff);
   end

   always_comb begin
      thr_ext    = DOT_W'($signed({1'b0, cfg.agree_min}));
      dot_abs    = s2_dot_ff[DOT_W-1] ? -s2_dot_ff : s2_dot_ff;
      overlap_ok = (s2_union_ff != '0) && !(s2_iden_ff < s2_unum_ff);
      // (dot + 1) / 2 > thr, scaled to Q2.28
      plane_ok   = (s2_dot_ff + (DOT_W'(1) <<< 28)) > (thr_ext <<< 15);
      cyl_ok     = dot_abs > (thr_ext <<< 14);
      o_sim_in   = 1'b0;
      if (overlap_ok) begin
         unique case ({s2_scyl_ff, s2_ocyl_ff})
            2'b00:   o_sim_in = plane_ok;
            2'b11:   o_sim_in = cyl_ok;
            2'b10:   o_sim_in = 1'b1;
            default: o_sim_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_scyl_ff  <= req.self_cyl;
         s1_ocyl_ff  <= req.other_cyl;
         s1_inter_ff <= req.inter;
         s1_union_ff <= req.uni;
         s1_px_ff    <= n_self.x * n_other.x;
         s1_py_ff    <= n_self.y * n_other.y;
         s1_pz_ff    <= n_self.z * n_other.z;
      end
      if (s2_load) begin
         s2_scyl_ff  <= s1_scyl_ff;
         s2_ocyl_ff  <= s1_ocyl_ff;
         s2_inter_ff <= s1_inter_ff;
         s2_union_ff <= s1_union_ff;
         s2_dot_ff   <= s2_dot_in;
         s2_iden_ff  <= RATIO_W'(s1_inter_ff) * RATIO_W'(cfg.ratio_den);
         s2_unum_ff  <= RATIO_W'(s1_union_ff) * RATIO_W'(cfg.ratio_num);
      end
      if (o_load) begin
         o_sim_ff   <= o_sim_in;
         o_inter_ff <= s2_inter_ff;
         o_union_ff <= s2_union_ff;
      end
   end

   assign out_valid   = o_valid_ff;
   assign out_similar = o_sim_ff;
   assign out_inter   = o_inter_ff;
   assign out_union   = o_union_ff;

endmodule

// ===== tb/sv/tb_mask_iou_shape_similarity.sv =====
// ----------------------------------------------------------------------------
// tb_mask_iou_shape_similarity
// Streams mask pixel groups with surface normals into the shape similarity block,
// predicts each pair's verdict and saturating pixel totals, and checks every
// result transfer in order. Covers the register extremes and random pairs
// under random idling on both streams, the last setting without idling.
// ----------------------------------------------------------------------------
module tb_mask_iou_shape_similarity;
   import mis_pkg::*;

   localparam bit KIND_PLANE    = 1'b0;
   localparam bit KIND_CYLINDER = 1'b1;
   localparam int Q14_ONE       = 16384;

   typedef struct packed {
      logic [MASK_W-1:0] self_bits;
      logic [MASK_W-1:0] other_bits;
      logic              last;
      logic              self_cyl;
      logic              other_cyl;
      normal_type        ns;
      normal_type        no;
   } pair_beat_type;

   typedef struct packed {
      logic             similar;
      logic [CNT_W-1:0] inter;
      logic [CNT_W-1:0] uni;
   } pair_verdict_type;

   class shape_match_board_type;
      logic [NUM_W-1:0]  ratio_num;
      logic [NUM_W-1:0]  ratio_den;
      logic [THR_W-1:0]  agree_min;
      longint unsigned   union_sum;
      longint unsigned   inter_sum;
      pair_verdict_type  awaited[$];
      int                errors;
      int                beats;
      int                judged;
      int                similar_seen;

      function new();
         ratio_num = RATIO_NUM_RESET;
         ratio_den = RATIO_DEN_RESET;
         agree_min = AGREE_MIN_RESET;
         union_sum = 0;
         inter_sum = 0;
         errors = 0;
         beats = 0;
         judged = 0;
         similar_seen = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_RATIO_NUM: ratio_num = v[NUM_W-1:0];
            REG_RATIO_DEN: ratio_den = v[NUM_W-1:0];
            REG_AGREE_MIN: agree_min = v[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned sat_px(longint unsigned v);
         return (v > MAX_PIXELS) ? longint'(MAX_PIXELS) : v;
      endfunction

      // one accepted input transfer
      function void take_beat(pair_beat_type b);
         longint           dot;
         longint           thr;
         longint           mag;
         pair_verdict_type v;
         beats++;
         union_sum = sat_px(union_sum + $countones(b.self_bits | b.other_bits));
         inter_sum = sat_px(inter_sum + $countones(b.self_bits & b.other_bits));
         if (!b.last) return;
         v.similar = 1'b0;
         if (union_sum != 0 && !(inter_sum * ratio_den < union_sum * ratio_num)) begin
            dot = longint'(b.ns.x) * longint'(b.no.x) + longint'(b.ns.y) * longint'(b.no.y)
                + longint'(b.ns.z) * longint'(b.no.z);
            thr = longint'(agree_min);
            mag = (dot < 0) ? -dot : dot;
            if (b.self_cyl == KIND_PLANE && b.other_cyl == KIND_PLANE)
               v.similar = (dot + (longint'(1) << 28)) > (thr << 15);
            else if (b.self_cyl == KIND_CYLINDER && b.other_cyl == KIND_CYLINDER)
               v.similar = mag > (thr << 14);
            else
               v.similar = (b.self_cyl == KIND_CYLINDER);
         end
         v.inter = inter_sum[CNT_W-1:0];
         v.uni = union_sum[CNT_W-1:0];
         awaited.push_back(v);
         union_sum = 0;
         inter_sum = 0;
      endfunction

      // one accepted result transfer
      function void check_verdict(logic [RSP_DATA_W-1:0] d);
         pair_verdict_type got;
         pair_verdict_type want;
         got.similar = d[0];
         got.inter = d[CNT_W:1];
         got.uni = d[2*CNT_W:CNT_W+1];
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result sim=%0d inter=%0d union=%0d",
                        got.similar, got.inter, got.uni);
            return;
         end
         want = awaited.pop_front();
         judged++;
         if (want.similar) similar_seen++;
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"ERROR: pair %0d: expected sim=%0d inter=%0d union=%0d,",
                         " got sim=%0d inter=%0d union=%0d"},
                        judged, want.similar, want.inter, want.uni,
                        got.similar, got.inter, got.uni);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   shape_match_board_type board;
   bit                    rsp_gaps_on = 1'b1;
   int                    stall_left = 0;
   int                    phases_run = 0;

   mask_iou_shape_similarity dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // result side: check transfers, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_verdict(rsp_tdata);
      if (stall_left == 0 && rsp_gaps_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 13);
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic normal_type nrm(int x, int y, int z);
      normal_type n;
      n.x = NORM_W'(x);
      n.y = NORM_W'(y);
      n.z = NORM_W'(z);
      return n;
   endfunction

   function automatic logic signed [NORM_W-1:0] clamp_q14(int v);
      if (v > Q14_ONE) return NORM_W'(Q14_ONE);
      if (v < -Q14_ONE) return NORM_W'(-Q14_ONE);
      return NORM_W'(v);
   endfunction

   function automatic int raw_q14();
      return int'($urandom_range(0, 2 * Q14_ONE)) - Q14_ONE;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 2))
         0: return -Q14_ONE;
         1: return 0;
         default: return Q14_ONE;
      endcase
   endfunction

   function automatic normal_type unit_normal();
      real x, y, z, len;
      x = real'($urandom_range(0, 2000)) - 1000.0;
      y = real'($urandom_range(0, 2000)) - 1000.0;
      z = real'($urandom_range(0, 2000)) - 1000.0;
      len = $sqrt(x * x + y * y + z * z);
      if (len < 1.0) begin
         x = 1000.0;
         len = 1000.0;
      end
      return nrm($rtoi(x / len * 16383.0), $rtoi(y / len * 16383.0),
                 $rtoi(z / len * 16383.0));
   endfunction

   // other normal close to +/- the given one
   function automatic normal_type near_normal(normal_type n, int spread, bit flip);
      normal_type o;
      int s;
      s = flip ? -1 : 1;
      o.x = clamp_q14(s * int'(n.x) + int'($urandom_range(0, 2 * spread)) - spread);
      o.y = clamp_q14(s * int'(n.y) + int'($urandom_range(0, 2 * spread)) - spread);
      o.z = clamp_q14(s * int'(n.z) + int'($urandom_range(0, 2 * spread)) - spread);
      return o;
   endfunction

   function automatic pair_beat_type make_beat(logic [7:0] sb, logic [7:0] ob, bit last,
                                               bit scyl, bit ocyl, normal_type ns,
                                               normal_type no);
      pair_beat_type b;
      b.self_bits = sb;
      b.other_bits = ob;
      b.last = last;
      b.self_cyl = scyl;
      b.other_cyl = ocyl;
      b.ns = ns;
      b.no = no;
      return b;
   endfunction

   task automatic send_beat(input pair_beat_type b, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b.no.z, b.no.y, b.no.x, b.ns.z, b.ns.y, b.ns.x,
                    b.other_bits, b.self_bits};
      req_tlast <= b.last;
      req_tuser <= {b.other_cyl, b.self_cyl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_beat(b);
   endtask

   // stop sending and let every outstanding verdict come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(input int num, input int den, input int thr);
      logic [1:0]            idx;
      logic [CSR_DATA_W-1:0] val;
      drain();
      for (int r = 0; r < 3; r++) begin
         case (r)
            0: begin idx = REG_RATIO_NUM; val = CSR_DATA_W'(num); end
            1: begin idx = REG_RATIO_DEN; val = CSR_DATA_W'(den); end
            default: begin idx = REG_AGREE_MIN; val = CSR_DATA_W'(thr); end
         endcase
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {idx, 2'b00};
         csr_pwdata <= val;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         board.set_reg(idx, val);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      phases_run++;
   endtask

   // one mask pair with random content, judged on its last beat
   task automatic send_pair(input int len, input bit gaps);
      pair_beat_type b;
      normal_type    n;
      int            mode;
      int            nmode;
      mode = $urandom_range(0, 19);
      for (int k = 0; k < len; k++) begin
         b.self_bits = MASK_W'($urandom_range(0, 255));
         if (mode == 0) begin
            b.self_bits = '0;
            b.other_bits = '0;
         end else if (mode <= 7) begin
            b.other_bits = b.self_bits;
         end else if (mode <= 14) begin
            b.other_bits = b.self_bits;
            if ($urandom_range(0, 2) == 0)
               b.other_bits[$urandom_range(0, 7)] ^= 1'b1;
         end else begin
            b.other_bits = MASK_W'($urandom_range(0, 255));
         end
         b.last = (k == len - 1);
         b.self_cyl = $urandom_range(0, 1) != 0;
         b.other_cyl = $urandom_range(0, 1) != 0;
         b.ns = nrm(raw_q14(), raw_q14(), raw_q14());
         b.no = nrm(raw_q14(), raw_q14(), raw_q14());
         if (b.last) begin
            nmode = $urandom_range(0, 9);
            if (nmode < 7) begin
               n = unit_normal();
               b.ns = n;
               b.no = near_normal(n, $urandom_range(0, 2000), $urandom_range(0, 1) != 0);
            end else if (nmode == 9) begin
               b.ns = nrm(pick_extreme(), pick_extreme(), pick_extreme());
               b.no = nrm(pick_extreme(), pick_extreme(), pick_extreme());
            end
         end
         send_beat(b, gaps);
      end
   endtask

   initial begin
      int         pair_len;
      int         phase_end;
      normal_type px;
      normal_type mx;
      normal_type pz;
      normal_type mz;
      normal_type py;
      board = new();
      px = nrm(Q14_ONE, 0, 0);
      mx = nrm(-Q14_ONE, 0, 0);
      pz = nrm(0, 0, Q14_ONE);
      mz = nrm(0, 0, -Q14_ONE);
      py = nrm(0, Q14_ONE, 0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values
      send_beat(make_beat(8'h00, 8'h00, 1'b1, KIND_PLANE, KIND_PLANE, px, px),
                1'b0); // empty union
      send_beat(make_beat(8'hFF, 8'hFF, 1'b1, KIND_PLANE, KIND_PLANE, px, px), 1'b0);
      send_beat(make_beat(8'hFF, 8'h01, 1'b1, KIND_CYLINDER, KIND_PLANE, px, px),
                1'b0); // low overlap
      send_beat(make_beat(8'h1F, 8'h01, 1'b1, KIND_CYLINDER, KIND_PLANE, mx, py),
                1'b0); // ratio tie
      send_beat(make_beat(8'hF0, 8'hF0, 1'b1, KIND_CYLINDER, KIND_CYLINDER, pz, mz), 1'b0);
      send_beat(make_beat(8'hAA, 8'hAA, 1'b1, KIND_PLANE, KIND_CYLINDER, pz, pz), 1'b0);
      send_beat(make_beat(8'h55, 8'h55, 1'b1, KIND_PLANE, KIND_PLANE, pz, mz), 1'b0);
      send_beat(make_beat(8'hFF, 8'h00, 1'b0, KIND_CYLINDER, KIND_CYLINDER, mz, pz), 1'b0);
      send_beat(make_beat(8'h00, 8'hFF, 1'b0, KIND_PLANE, KIND_PLANE, mx, px), 1'b0);
      send_beat(make_beat(8'hFF, 8'hFF, 1'b1, KIND_PLANE, KIND_PLANE,
                          nrm(-Q14_ONE, -Q14_ONE, -Q14_ONE),
                          nrm(-Q14_ONE, -Q14_ONE, -Q14_ONE)), 1'b0);

      // strictest threshold: parallel normals sit exactly on the boundary
      apply_settings(1, 1, Q14_ONE);
      send_beat(make_beat(8'hFF, 8'hFF, 1'b1, KIND_PLANE, KIND_PLANE, px, px), 1'b0);
      send_beat(make_beat(8'hFF, 8'hFF, 1'b1, KIND_CYLINDER, KIND_CYLINDER, pz, mz), 1'b0);
      send_beat(make_beat(8'h0F, 8'h0E, 1'b1, KIND_CYLINDER, KIND_PLANE, pz, pz), 1'b0);

      apply_settings(255, 1, 0);
      send_beat(make_beat(8'hFF, 8'hFF, 1'b1, KIND_CYLINDER, KIND_PLANE, px, px), 1'b0);

      // loosest: zero threshold against zero and opposite dot
      apply_settings(1, 255, 0);
      send_beat(make_beat(8'h01, 8'h80, 1'b0, KIND_PLANE, KIND_PLANE, px, px), 1'b0);
      send_beat(make_beat(8'h03, 8'h01, 1'b1, KIND_PLANE, KIND_PLANE, px, mx), 1'b0);
      send_beat(make_beat(8'h81, 8'h81, 1'b1, KIND_CYLINDER, KIND_CYLINDER, px, py), 1'b0);
      send_beat(make_beat(8'h81, 8'h81, 1'b1, KIND_PLANE, KIND_PLANE, px, py), 1'b0);

      // random pairs in several register settings, last one without idling
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: apply_settings(1, 5, 15565);
            1: apply_settings(1, 255, 0);
            2: apply_settings(255, 255, Q14_ONE);
            3: apply_settings(3, 4, 12000);
            default: begin
               rsp_gaps_on = 1'b0;
               apply_settings($urandom_range(1, 64), $urandom_range(64, 255),
                              $urandom_range(8000, Q14_ONE));
            end
         endcase
         phase_end = board.beats + 280;
         while (board.beats < phase_end) begin
            case ($urandom_range(0, 19))
               0: pair_len = 1;
               1, 2, 3: pair_len = $urandom_range(7, 40);
               default: pair_len = $urandom_range(1, 6);
            endcase
            send_pair(pair_len, ph != 4 && $urandom_range(0, 3) != 0);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Summary: %0d beats, %0d pairs judged (%0d similar)",
               board.beats, board.judged, board.similar_seen);
      $display("         over %0d register settings, with register extremes and idling",
               phases_run + 1);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
